/* hdl/hrcd_pkg.sv */
// ----------------------------------------------------------------------------
// hrcd_pkg
// shared types, constants and helpers of the request completion detector
// ----------------------------------------------------------------------------
package hrcd_pkg;

    localparam int COUNT_BITS     = 32;
    localparam int LEN_BITS       = 17;
    localparam int MAX_BODY_BYTES = 65536;
    localparam int NAME_LEN       = 15;
    localparam int NAME_BITS      = $clog2(NAME_LEN + 1);
    localparam int PROD_BITS      = LEN_BITS + 4;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [LEN_BITS-1:0]   t_len;

    localparam t_count COUNT_MAX = '1;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5A;

    // terminator matcher: none, cr, cr lf, cr lf cr, lone lf
    typedef enum logic [2:0] {
        TERM_NONE,
        TERM_CR,
        TERM_CRLF,
        TERM_CRLFCR,
        TERM_LF
    } t_term;

    typedef enum logic [1:0] {
        VAL_SEARCH,
        VAL_SKIP,
        VAL_DIGITS,
        VAL_OVER
    } t_phase;

    typedef struct packed {
        t_term                 term;
        logic                  line_match;
        logic                  prev_cr;
        logic [NAME_BITS-1:0]  name_pos;
        t_phase                phase;
        t_len                  acc;
        logic                  too_large;
        logic                  line_closed;
        logic                  has_digits;
    } t_parse;

    localparam t_parse PARSE_RESET = '{
        term:        TERM_NONE,
        line_match:  1'b1,
        prev_cr:     1'b0,
        name_pos:    '0,
        phase:       VAL_SEARCH,
        acc:         '0,
        too_large:   1'b0,
        line_closed: 1'b0,
        has_digits:  1'b0
    };

    typedef struct packed {
        t_count byte_count;
        t_count hdr_end;
        logic   done;
    } t_track;

    localparam t_track TRACK_RESET = '{byte_count: '0, hdr_end: '0, done: 1'b0};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in;

    typedef struct packed {
        logic complete;
        logic header_done;
        logic body_len_known;
        t_len body_len;
    } t_result;

    // lower-case field name, one character per position
    function automatic logic [7:0] name_char(input logic [NAME_BITS-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
    endfunction

endpackage

/* hdl/hrcd_if.sv */
// ----------------------------------------------------------------------------
// hrcd_in_if / hrcd_out_if
// valid/ready channels for request bytes and completion results
// ----------------------------------------------------------------------------
interface hrcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hrcd_out_if;
    logic                 valid;
    logic                 ready;
    logic                 complete;
    logic                 header_done;
    logic                 body_len_known;
    hrcd_pkg::t_len       body_len;

    modport source (output valid, output complete, output header_done,
                    output body_len_known, output body_len, input ready);
    modport sink   (input valid, input complete, input header_done,
                    input body_len_known, input body_len, output ready);
endinterface

/* hdl/http_request_completion_detector.sv */
// ----------------------------------------------------------------------------
// http_request_completion_detector
// per-byte http request completeness: header end and body length tracking
// ----------------------------------------------------------------------------
// path: input register, then the parse/count update, then the result register
// throughput: one byte per cycle while the result side takes them, set by the
//   single-pass parse/count update between the input and result registers
// reset: i_rst_n low clears parse and count state and both valid flags;
//   first_byte on a byte clears all request state before that byte
// ----------------------------------------------------------------------------
module http_request_completion_detector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hrcd_in_if.sink            i_req,
    hrcd_out_if.source         o_res
);

    // input register
    logic               r_in_valid;
    hrcd_pkg::t_in      r_in;

    // request state
    hrcd_pkg::t_parse   r_parse;
    hrcd_pkg::t_track   r_track;

    // result register
    logic               r_out_valid;
    hrcd_pkg::t_result  r_out;

    hrcd_pkg::t_parse   cur_parse;
    hrcd_pkg::t_track   cur_track;
    hrcd_pkg::t_parse   step_parse;
    hrcd_pkg::t_parse   n_parse;
    hrcd_pkg::t_track   n_track;
    hrcd_pkg::t_result  n_out;
    logic               ended;
    logic               advance;

    // the held byte moves on when the result slot is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    // a first byte starts from clean state
    assign cur_parse = r_in.first_byte ? hrcd_pkg::PARSE_RESET : r_parse;
    assign cur_track = r_in.first_byte ? hrcd_pkg::TRACK_RESET : r_track;

    hrcd_parse u_parse (
        .i_state (cur_parse),
        .i_byte  (r_in.data_byte),
        .o_state (step_parse),
        .o_ended (ended)
    );

    // after the header end the parser is frozen, bytes are only counted
    assign n_parse = (cur_track.hdr_end == '0) ? step_parse : cur_parse;

    hrcd_complete u_complete (
        .i_track  (cur_track),
        .i_ended  (ended),
        .i_parse  (n_parse),
        .o_track  (n_track),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.data_byte  <= i_req.data_byte;
            r_in.first_byte <= i_req.first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse <= hrcd_pkg::PARSE_RESET;
            r_track <= hrcd_pkg::TRACK_RESET;
        end else if (advance) begin
            r_parse <= n_parse;
            r_track <= n_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.complete       = r_out.complete;
    assign o_res.header_done    = r_out.header_done;
    assign o_res.body_len_known = r_out.body_len_known;
    assign o_res.body_len       = r_out.body_len;

    // completion stays latched within a request
    a_done_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.first_byte && r_track.done |-> n_track.done)
        else $error("completion flag dropped within a request");

    // complete never precedes the header end
    a_done_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.complete |-> r_out.header_done)
        else $error("complete without header end");

    // unknown length reads as zero
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.body_len_known |-> r_out.body_len == '0)
        else $error("body length nonzero while unknown");

    // parser frozen once the header has ended
    a_parse_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in.first_byte && r_track.hdr_end != '0 |=> $stable(r_parse))
        else $error("parser state moved after header end");

    // a held byte is not lost while the result slot is full
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("held input byte overwritten");

endmodule

/* hdl/hrcd_parse.sv */
// ----------------------------------------------------------------------------
// hrcd_parse
// per-byte header terminator, field name and length value matcher
// ----------------------------------------------------------------------------
module hrcd_parse (
    input  hrcd_pkg::t_parse i_state,
    input  logic [7:0]       i_byte,
    output hrcd_pkg::t_parse o_state,
    output logic             o_ended
);

    logic [7:0]                   lc;
    logic                         is_digit;
    logic                         crlf;
    logic [hrcd_pkg::LEN_BITS-1:0] digit;
    logic [hrcd_pkg::PROD_BITS-1:0] prod;
    hrcd_pkg::t_parse             n_state;

    assign lc       = hrcd_pkg::to_lower(i_byte);
    assign is_digit = (i_byte >= hrcd_pkg::CH_0) && (i_byte <= hrcd_pkg::CH_9);
    assign crlf     = i_state.prev_cr && (i_byte == hrcd_pkg::CH_LF);
    assign digit    = hrcd_pkg::LEN_BITS'(i_byte - hrcd_pkg::CH_0);

    // acc * 10 + digit, shifts and adds
    assign prod = ({4'b0, i_state.acc} << 3) + ({4'b0, i_state.acc} << 1)
                + hrcd_pkg::PROD_BITS'(digit);

    always_comb begin
        n_state = i_state;
        o_ended = 1'b0;

        if (i_state.phase == hrcd_pkg::VAL_SEARCH && i_state.line_match) begin
            if (i_state.name_pos < hrcd_pkg::NAME_BITS'(hrcd_pkg::NAME_LEN) &&
                lc == hrcd_pkg::name_char(i_state.name_pos)) begin
                n_state.name_pos = i_state.name_pos + hrcd_pkg::NAME_BITS'(1);
                if (i_state.name_pos == hrcd_pkg::NAME_BITS'(hrcd_pkg::NAME_LEN - 1)) begin
                    n_state.phase      = hrcd_pkg::VAL_SKIP;
                    n_state.line_match = 1'b0;
                end
            end else begin
                n_state.line_match = 1'b0;
            end
        end else if (i_state.phase == hrcd_pkg::VAL_SKIP) begin
            if (is_digit) begin
                n_state.acc        = digit;
                n_state.has_digits = 1'b1;
                n_state.phase      = hrcd_pkg::VAL_DIGITS;
            end else if (i_byte != hrcd_pkg::CH_SP) begin
                n_state.phase = hrcd_pkg::VAL_OVER;
            end
        end else if (i_state.phase == hrcd_pkg::VAL_DIGITS) begin
            if (is_digit) begin
                if (!i_state.too_large) begin
                    if (prod > hrcd_pkg::PROD_BITS'(hrcd_pkg::MAX_BODY_BYTES)) begin
                        n_state.too_large = 1'b1;
                        n_state.acc       = '0;
                    end else begin
                        n_state.acc = prod[hrcd_pkg::LEN_BITS-1:0];
                    end
                end
            end else begin
                n_state.phase = hrcd_pkg::VAL_OVER;
            end
        end

        // end of line: restart name match, or close the length line
        if (crlf) begin
            if (n_state.phase == hrcd_pkg::VAL_SEARCH) begin
                n_state.line_match = 1'b1;
                n_state.name_pos   = '0;
            end else if (!n_state.line_closed) begin
                n_state.line_closed = 1'b1;
                n_state.phase       = hrcd_pkg::VAL_OVER;
            end
        end

        case (i_byte)
            hrcd_pkg::CH_LF: begin
                o_ended = (i_state.term == hrcd_pkg::TERM_CRLF) ||
                          (i_state.term == hrcd_pkg::TERM_LF) ||
                          (i_state.term == hrcd_pkg::TERM_CRLFCR);
                n_state.term = i_state.prev_cr ? hrcd_pkg::TERM_CRLF : hrcd_pkg::TERM_LF;
            end
            hrcd_pkg::CH_CR: begin
                n_state.term = (i_state.term == hrcd_pkg::TERM_CRLF) ?
                               hrcd_pkg::TERM_CRLFCR : hrcd_pkg::TERM_CR;
            end
            default: begin
                n_state.term = hrcd_pkg::TERM_NONE;
            end
        endcase

        n_state.prev_cr = (i_byte == hrcd_pkg::CH_CR);
    end

    assign o_state = n_state;

endmodule

/* hdl/hrcd_complete.sv */
// ----------------------------------------------------------------------------
// hrcd_complete
// byte counting, header end position and latched completion decision
// ----------------------------------------------------------------------------
module hrcd_complete (
    input  hrcd_pkg::t_track  i_track,
    input  logic              i_ended,
    input  hrcd_pkg::t_parse  i_parse,
    output hrcd_pkg::t_track  o_track,
    output hrcd_pkg::t_result o_result
);

    hrcd_pkg::t_count             bc_inc;
    logic [hrcd_pkg::COUNT_BITS:0] sum;
    hrcd_pkg::t_count             target;
    logic                         open;
    logic                         known;
    logic                         reach;
    hrcd_pkg::t_track             n_track;

    assign open   = (i_track.hdr_end == '0);
    assign bc_inc = (i_track.byte_count == hrcd_pkg::COUNT_MAX) ?
                    i_track.byte_count : i_track.byte_count + hrcd_pkg::t_count'(1);
    assign known  = i_parse.line_closed && i_parse.has_digits && !i_parse.too_large;

    // saturating header end plus body length
    assign sum    = {1'b0, i_track.hdr_end}
                  + (hrcd_pkg::COUNT_BITS + 1)'(i_parse.acc);
    assign target = sum[hrcd_pkg::COUNT_BITS] ? hrcd_pkg::COUNT_MAX
                                              : sum[hrcd_pkg::COUNT_BITS-1:0];

    always_comb begin
        n_track            = i_track;
        n_track.byte_count = bc_inc;
        reach              = 1'b0;
        if (open) begin
            if (i_ended) begin
                // header end equals the new count here
                n_track.hdr_end = bc_inc;
                reach = (i_parse.acc == '0) || (bc_inc == hrcd_pkg::COUNT_MAX);
            end
        end else begin
            reach = (bc_inc >= target);
        end
        if (n_track.hdr_end != '0 && (!known || reach)) begin
            n_track.done = 1'b1;
        end
    end

    assign o_track                 = n_track;
    assign o_result.complete       = n_track.done;
    assign o_result.header_done    = (n_track.hdr_end != '0);
    assign o_result.body_len_known = known;
    assign o_result.body_len       = known ? i_parse.acc : '0;

endmodule

/* dv/http_request_completion_detector_checker.sv */
// ----------------------------------------------------------------------------
// http_request_completion_detector_checker
// watches both channels, predicts each result word from the accepted request
// bytes and compares it field by field; hands failures and backlog to the top
// ----------------------------------------------------------------------------
module http_request_completion_detector_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hrcd_in_if   i_req,
    hrcd_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*hrcd_pkg::NAME_LEN-1:0] LEN_FIELD = "content-length:";

    // parse and count state of the current request
    hrcd_pkg::t_count  seen_bytes;
    hrcd_pkg::t_term   term_st;
    hrcd_pkg::t_count  hdr_end_at;
    logic              name_live;
    logic              last_cr;
    int unsigned       name_idx;
    hrcd_pkg::t_phase  len_phase;
    int unsigned       len_value;
    logic              len_overflow;
    logic              len_closed;
    logic              saw_digit;
    logic              completed;

    hrcd_pkg::t_result status_q[$];
    hrcd_pkg::t_result want_word;
    hrcd_pkg::t_result next_word;

    function automatic hrcd_pkg::t_count sat_count(input hrcd_pkg::t_count a,
                                                   input hrcd_pkg::t_count b);
        logic [hrcd_pkg::COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[hrcd_pkg::COUNT_BITS] ? hrcd_pkg::COUNT_MAX
                                       : s[hrcd_pkg::COUNT_BITS-1:0];
    endfunction

    task automatic clear_parse();
        seen_bytes   = '0;
        term_st      = hrcd_pkg::TERM_NONE;
        hdr_end_at   = '0;
        name_live    = 1'b1;
        last_cr      = 1'b0;
        name_idx     = 0;
        len_phase    = hrcd_pkg::VAL_SEARCH;
        len_value    = 0;
        len_overflow = 1'b0;
        len_closed   = 1'b0;
        saw_digit    = 1'b0;
        completed    = 1'b0;
    endtask

    task automatic advance_parse(input logic [7:0] b, input logic restart,
                                 output hrcd_pkg::t_result r);
        logic        crlf;
        logic        digit;
        logic        term_hit;
        logic        known;
        logic [7:0]  lc;
        int unsigned v;
        if (restart) clear_parse();
        // header bytes drive the matchers, body bytes are only counted
        if (hdr_end_at == '0) begin
            crlf     = last_cr && (b == hrcd_pkg::CH_LF);
            digit    = (b >= hrcd_pkg::CH_0) && (b <= hrcd_pkg::CH_9);
            term_hit = 1'b0;
            lc       = (b >= hrcd_pkg::CH_UA && b <= hrcd_pkg::CH_UZ) ? b + 8'd32 : b;
            if (len_phase == hrcd_pkg::VAL_SEARCH && name_live) begin
                if (name_idx < hrcd_pkg::NAME_LEN &&
                    lc == LEN_FIELD[8*(hrcd_pkg::NAME_LEN-1-name_idx) +: 8]) begin
                    name_idx++;
                    if (name_idx == hrcd_pkg::NAME_LEN) begin
                        len_phase = hrcd_pkg::VAL_SKIP;
                        name_live = 1'b0;
                    end
                end else begin
                    name_live = 1'b0;
                end
            end else if (len_phase == hrcd_pkg::VAL_SKIP) begin
                if (digit) begin
                    len_value = b - hrcd_pkg::CH_0;
                    saw_digit = 1'b1;
                    len_phase = hrcd_pkg::VAL_DIGITS;
                end else if (b != hrcd_pkg::CH_SP) begin
                    len_phase = hrcd_pkg::VAL_OVER;
                end
            end else if (len_phase == hrcd_pkg::VAL_DIGITS) begin
                if (!digit) begin
                    len_phase = hrcd_pkg::VAL_OVER;
                end else if (!len_overflow) begin
                    v = len_value * 10 + (b - hrcd_pkg::CH_0);
                    if (v > hrcd_pkg::MAX_BODY_BYTES) begin
                        len_overflow = 1'b1;
                        len_value    = 0;
                    end else begin
                        len_value = v;
                    end
                end
            end
            if (crlf) begin
                if (len_phase == hrcd_pkg::VAL_SEARCH) begin
                    name_live = 1'b1;
                    name_idx  = 0;
                end else if (!len_closed) begin
                    len_closed = 1'b1;
                    len_phase  = hrcd_pkg::VAL_OVER;
                end
            end
            if (b == hrcd_pkg::CH_LF) begin
                term_hit = (term_st == hrcd_pkg::TERM_CRLF) ||
                           (term_st == hrcd_pkg::TERM_CRLFCR) ||
                           (term_st == hrcd_pkg::TERM_LF);
                term_st  = last_cr ? hrcd_pkg::TERM_CRLF : hrcd_pkg::TERM_LF;
            end else if (b == hrcd_pkg::CH_CR) begin
                term_st = (term_st == hrcd_pkg::TERM_CRLF) ? hrcd_pkg::TERM_CRLFCR
                                                           : hrcd_pkg::TERM_CR;
            end else begin
                term_st = hrcd_pkg::TERM_NONE;
            end
            if (term_hit) hdr_end_at = sat_count(seen_bytes, 1);
            last_cr = (b == hrcd_pkg::CH_CR);
        end
        seen_bytes = sat_count(seen_bytes, 1);
        known = len_closed && saw_digit && !len_overflow;
        if (hdr_end_at != '0 &&
            (!known ||
             seen_bytes >= sat_count(hdr_end_at, hrcd_pkg::t_count'(len_value))))
            completed = 1'b1;
        r.complete       = completed;
        r.header_done    = (hdr_end_at != '0);
        r.body_len_known = known;
        r.body_len       = known ? hrcd_pkg::t_len'(len_value) : '0;
    endtask

    task automatic flag_field(input string fld,
                              input logic [hrcd_pkg::LEN_BITS-1:0] want,
                              input logic [hrcd_pkg::LEN_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, fld, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            status_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (status_q.size() == 0) begin
                    $display("%0t ns: result word with none expected, expected none, got %h",
                             $time, {i_res.complete, i_res.header_done,
                                     i_res.body_len_known, i_res.body_len});
                    o_fail_count++;
                end else begin
                    want_word = status_q.pop_front();
                    flag_field("complete", want_word.complete, i_res.complete);
                    flag_field("header_done", want_word.header_done, i_res.header_done);
                    flag_field("body_len_known", want_word.body_len_known,
                               i_res.body_len_known);
                    flag_field("body_len", want_word.body_len, i_res.body_len);
                end
            end
            if (i_req.valid && i_req.ready) begin
                advance_parse(i_req.data_byte, i_req.first_byte, next_word);
                status_q.push_back(next_word);
            end
        end
        o_pending <= status_q.size();
    end

endmodule

/* dv/http_request_completion_detector_tb.sv */
// ----------------------------------------------------------------------------
// http_request_completion_detector_tb
// drives http request text byte by byte with bursty input and a stalling
// result side; a checker beside the block predicts and compares every word
// ----------------------------------------------------------------------------
module http_request_completion_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD  = 5;
    localparam int          RANDOM_BYTES = 600;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          SETTLE       = 4;
    localparam longint      TIMEOUT_NS   = 2_000_000;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_PLUS      = 8'h2B;
    localparam logic [7:0]  CH_MINUS     = 8'h2D;

    typedef enum logic {RX_OPEN, RX_CHOPPY} t_rx_style;

    logic clk = 1'b0;
    logic rst_n;

    hrcd_in_if  req_if ();
    hrcd_out_if res_if ();

    int         fail_count;
    int         pending;

    // sender shaping: bursts of words separated by idle gaps when gappy
    bit         tx_gappy;
    int         burst_left;
    // receiver shaping, plus a one-shot long hold-off request
    t_rx_style  rx_mode = RX_OPEN;
    bit         hold_request;
    bit         rx_on;
    int         rx_left;

    // bytes of the request being assembled
    logic [7:0] req_bytes[$];
    int         random_bytes;
    bit         hold_done;
    bit         drain_done;

    always #(HALF_PERIOD) clk = ~clk;

    http_request_completion_detector dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    http_request_completion_detector_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ------------------------------------------------------------------
    // request text builders
    // ------------------------------------------------------------------
    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endtask

    task automatic add_crlf();
        req_bytes.push_back(hrcd_pkg::CH_CR);
        req_bytes.push_back(hrcd_pkg::CH_LF);
    endtask

    // content-length line with random letter case; sometimes a spoiled name,
    // a sign or tab before the digits, no digits, leading zeros, trailing
    // text after the digits, or a bare lf instead of cr lf
    task automatic append_length_line(input int unsigned v);
        string       name_txt = "content-length:";
        logic [7:0]  c;
        int unsigned spoil;
        spoil = ($urandom_range(0, 15) == 0) ?
                $urandom_range(0, hrcd_pkg::NAME_LEN - 1) : hrcd_pkg::NAME_LEN;
        for (int i = 0; i < hrcd_pkg::NAME_LEN; i++) begin
            c = name_txt[i];
            if (i == spoil)
                c = 8'($urandom_range(0, 255));
            else if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            req_bytes.push_back(c);
        end
        case ($urandom_range(0, 11))
            0:       req_bytes.push_back(CH_TAB);
            1:       req_bytes.push_back(CH_PLUS);
            2:       req_bytes.push_back(CH_MINUS);
            default: repeat ($urandom_range(0, 3)) req_bytes.push_back(hrcd_pkg::CH_SP);
        endcase
        if ($urandom_range(0, 15) != 0) begin
            if ($urandom_range(0, 5) == 0) append_text("00");
            append_text($sformatf("%0d", v));
        end
        if ($urandom_range(0, 5) == 0) append_text(" ;q=x");
        if ($urandom_range(0, 9) == 0) req_bytes.push_back(hrcd_pkg::CH_LF);
        else add_crlf();
    endtask

    // other header line: short, mostly printable, now and then any byte
    task automatic append_filler_line();
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 7) == 0)
                req_bytes.push_back(8'($urandom_range(0, 255)));
            else
                req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        add_crlf();
    endtask

    // one request: mostly a well-formed header with a length line and a
    // matching body; the rest are requests without the line, cut-off or
    // overlong bodies, and plain noise rich in line breaks
    task automatic build_request();
        int unsigned kind;
        int unsigned n_lines;
        int unsigned cl_slot;
        int unsigned len_val;
        int unsigned body_n;
        logic [7:0]  c;
        req_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 20)) begin
                case ($urandom_range(0, 3))
                    0:       c = hrcd_pkg::CH_CR;
                    1:       c = hrcd_pkg::CH_LF;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                req_bytes.push_back(c);
            end
            return;
        end
        n_lines = $urandom_range(0, 2);
        // a slot past the last line means no length line at all
        cl_slot = (kind < 18) ? n_lines + 1 : $urandom_range(0, n_lines);
        case ($urandom_range(0, 9))
            0:       len_val = hrcd_pkg::MAX_BODY_BYTES - 1 + $urandom_range(0, 2);
            1:       len_val = $urandom_range(hrcd_pkg::MAX_BODY_BYTES + 2, 999999);
            default: len_val = $urandom_range(0, 24);
        endcase
        for (int i = 0; i <= n_lines; i++) begin
            if (i == cl_slot) begin
                append_length_line(len_val);
                // a later length line must be ignored
                if ($urandom_range(0, 7) == 0) append_length_line($urandom_range(0, 30));
            end
            if (i < n_lines) append_filler_line();
        end
        if ($urandom_range(0, 5) == 0) req_bytes.push_back(hrcd_pkg::CH_LF);
        else add_crlf();
        if (len_val <= 40) begin
            case ($urandom_range(0, 7))
                0:       body_n = $urandom_range(0, len_val);
                1:       body_n = len_val + $urandom_range(1, 4);
                default: body_n = len_val;
            endcase
        end else begin
            body_n = $urandom_range(0, 6);
        end
        repeat (body_n) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // sender: one word per call, entered and left at a falling edge with
    // valid still high so back-to-back words need no extra assignment
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic f);
        int unsigned gap;
        if (tx_gappy && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (burst_left > 0) burst_left--;
        req_if.valid      <= 1'b1;
        req_if.data_byte  <= b;
        req_if.first_byte <= f;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic mark_first);
        foreach (req_bytes[i]) send_word(req_bytes[i], mark_first && i == 0);
    endtask

    // ------------------------------------------------------------------
    // receiver: open, or alternating ready and stall runs of random length;
    // a hold request takes ready low for a long stretch counted here
    // ------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end else if (rx_mode == RX_OPEN) begin
                res_if.ready <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_on   = !rx_on;
                    rx_left = rx_on ? $urandom_range(1, 10) : $urandom_range(1, 4);
                end
                rx_left--;
                res_if.ready <= rx_on;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.data_byte  = '0;
        req_if.first_byte = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: byte zero and all-ones in the header, a lone lf lf end,
        // then a byte after the header end that is only counted
        tx_gappy  = 1'b0;
        req_bytes = {8'h00, 8'hFF, hrcd_pkg::CH_LF, hrcd_pkg::CH_LF, 8'h78};
        send_bytes(1'b1);
        // directed: mixed-case name at byte 0, a skipped space, cr lf cr lf
        // end and a two byte body; restart flag clears the latched state
        req_bytes.delete();
        append_text("CONTENT-length: 2");
        add_crlf();
        add_crlf();
        append_text("ab");
        send_bytes(1'b1);

        // random requests; modes change per request so gaps and stalls land
        // on every phase, with some stretches fully open on both sides
        while (random_bytes < RANDOM_BYTES) begin
            tx_gappy = ($urandom_range(0, 3) != 0);
            rx_mode  = ($urandom_range(0, 2) == 0) ? RX_OPEN : RX_CHOPPY;
            // long receiver hold while the sender keeps offering words
            if (!hold_done && random_bytes >= 200) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            // sender goes quiet until every expected word has drained
            if (!drain_done && random_bytes >= 400) begin
                req_if.valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
                drain_done = 1'b1;
            end
            build_request();
            send_bytes($urandom_range(0, 9) != 0);
            random_bytes += req_bytes.size();
        end
        req_if.valid <= 1'b0;

        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("http_request_completion_detector regression: pass");
        else
            $display("http_request_completion_detector regression: fail");
        $finish;
    end

    // run limit far above the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("http_request_completion_detector regression: fail");
        $finish;
    end

endmodule
